[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the plant model core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/npms_pkg.sv]
// Types and constants of the nonlinear plant model core.
package npms_pkg;

    localparam int DATA_W   = 32;
    localparam int MCAND_W  = 48;
    localparam int MPLIER_W = 33;
    localparam int ACC_W    = MCAND_W + 1;
    localparam int PROD_W   = ACC_W + MPLIER_W;
    localparam int SUM_W    = PROD_W - 16;
    localparam int REM_W    = 36;
    localparam int SHIFT_W  = 48;
    localparam int CNT_W    = 6;
    localparam int SINE_W   = 18;
    localparam int IDX_W    = 3;

    localparam logic [REM_W-1:0] PI2_Q32 = 36'd26986075409;
    localparam logic [REM_W-1:0] PI_Q32  = 36'd13493037705;
    localparam logic [REM_W-1:0] PIH_Q32 = 36'd6746518852;
    localparam logic [MPLIER_W-1:0] ONE_Q30 = 33'd1073741824;

    localparam logic [CNT_W-1:0] MUL_LAST  = 6'd32;
    localparam logic [CNT_W-1:0] DIV_LAST  = 6'd32;
    localparam logic [CNT_W-1:0] MOD_LAST  = 6'd47;
    localparam logic [CNT_W-1:0] FOLD_LAST = 6'd2;

    localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_A = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_B = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_C = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_D = 3'd4;
    localparam logic [IDX_W-1:0] REG_Y_INIT = 3'd5;

    localparam logic [DATA_W-1:0] COEF_A_RESET = 32'd52429;
    localparam logic [DATA_W-1:0] COEF_B_RESET = 32'd32768;
    localparam logic [DATA_W-1:0] COEF_C_RESET = 32'd19661;
    localparam logic [DATA_W-1:0] COEF_D_RESET = 32'd13107;
    localparam logic [DATA_W-1:0] Y_INIT_RESET = 32'd1310720;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LOAD = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_MOD  = 8'b0001_0000,
        ST_FOLD = 8'b0010_0000,
        ST_POST = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    typedef enum logic [3:0] {
        PH_A, PH_SQ, PH_B2, PH_C, PH_MOD, PH_X2, PH_D72, PH_H42,
        PH_D42, PH_H20, PH_D20, PH_H6, PH_D6, PH_S, PH_D, PH_BL
    } phase_t;

endpackage

[hw/rtl/nonlinear_plant_model_step_core.sv]
// Top level of the nonlinear plant model core: sequencer and serial datapath.
//
// Each input request carries one Q16.16 heat sample (s_u_sample) and a restart
// flag; the block answers with one Q16.16 plant output (m_y_next) and a flag
// that tells whether the sum was clipped to the 32-bit range (m_saturated).
// Both channels use valid/ready; a request moves when valid and ready are high.
// Coefficients and the mode are written through the cfg_* port, which is
// always ready; indexes 0..5 address model_mode, coef_a, coef_b, coef_c,
// coef_d and y_initial, higher indexes are ignored.
// All products go through one shift-add multiplier that retires one bit of
// the multiplier per cycle, and constant divisions and the 2*pi range
// reduction go through one restoring divider that retires one bit per cycle.
// The block takes one request at a time. A finished result sits in the output
// register, and a new request is accepted while it waits; if the receiver
// still stalls when the next result is done, the core holds in its final state.
// Reset loads the register defaults, sets the output history to y_initial,
// clears the input history and drops m_valid.
module nonlinear_plant_model_step_core
    import npms_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_u_sample,
    input  logic                     s_restart,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_y_next,
    output logic                     m_saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

`include "assert_macros.svh"

    // Control and configuration registers.
    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      mode_reg;
    logic signed [DATA_W-1:0]  coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [DATA_W-1:0]  y_init_reg;
    logic signed [DATA_W-1:0]  yc_reg, yc_next, ye_reg, ye_next, ue_reg, ue_next;

    // Datapath registers.
    logic signed [DATA_W-1:0]   u_reg, u_next;
    logic signed [MCAND_W-1:0]  mcand_reg, mcand_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [MPLIER_W-1:0]        lo_reg, lo_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [SHIFT_W-1:0]         sh_reg, sh_next;
    logic                       neg_reg, neg_next;
    logic [DATA_W-1:0]          x_reg, x_next;
    logic [MPLIER_W-1:0]        x2_reg, x2_next, t_reg, t_next, h_reg, h_next;
    logic [MCAND_W-1:0]         sq_reg, sq_next;
    logic signed [SINE_W-1:0]   sv_reg, sv_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [DATA_W-1:0]   y_out_reg, y_out_next;
    logic                       sat_out_reg, sat_out_next;

    // Datapath helpers.
    logic [PROD_W-1:0]          prod;
    logic [SUM_W-1:0]           p_hi;
    logic                       p_rnd;
    logic signed [ACC_W-1:0]    addend;
    logic signed [ACC_W:0]      acc_sum;
    logic [REM_W-1:0]           divisor, trial;
    logic                       trial_ge;
    logic [DATA_W-1:0]          u_mag;
    logic [MPLIER_W:0]          v_full;
    logic [SINE_W-1:0]          v_mag;
    logic                       sum_hi, sum_lo;

    assign s_ready     = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_y_next    = y_out_reg;
    assign m_saturated = sat_out_reg;

    assign prod  = {acc_reg, lo_reg};
    assign p_hi  = prod[PROD_W-1:16];
    assign p_rnd = prod[15];

    // One multiplier bit per cycle; the top bit of the multiplier has negative weight.
    always_comb begin
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (cnt_reg == MUL_LAST) begin
            addend = -{mcand_reg[MCAND_W-1], mcand_reg};
        end else begin
            addend = {mcand_reg[MCAND_W-1], mcand_reg};
        end
        acc_sum = $signed({acc_reg[ACC_W-1], acc_reg}) + $signed({addend[ACC_W-1], addend});
    end

    // Restoring divider step, shared by range reduction and constant divisions.
    always_comb begin
        if (state_reg == ST_MOD) begin
            divisor = PI2_Q32;
        end else begin
            case (phase_reg)
                PH_D72:  divisor = REM_W'(72);
                PH_D42:  divisor = REM_W'(42);
                PH_D20:  divisor = REM_W'(20);
                PH_D6:   divisor = REM_W'(6);
                default: divisor = REM_W'(6);
            endcase
        end
        trial    = {rem_reg[REM_W-2:0], sh_reg[SHIFT_W-1]};
        trial_ge = (trial >= divisor);
    end

    // The sine term works on the previous input sample.
    assign u_mag  = ue_reg[DATA_W-1] ? DATA_W'(-ue_reg) : DATA_W'(ue_reg);
    assign v_full = {1'b0, prod[62:30]} + (MPLIER_W+1)'(8192);
    assign v_mag  = v_full[31:14];
    assign sum_hi = !sum_reg[SUM_W-1] && (|sum_reg[SUM_W-2:DATA_W-1]);
    assign sum_lo = sum_reg[SUM_W-1] && !(&sum_reg[SUM_W-2:DATA_W-1]);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        yc_next      = yc_reg;
        ye_next      = ye_reg;
        ue_next      = ue_reg;
        u_next       = u_reg;
        mcand_next   = mcand_reg;
        acc_next     = acc_reg;
        lo_next      = lo_reg;
        rem_next     = rem_reg;
        sh_next      = sh_reg;
        neg_next     = neg_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        t_next       = t_reg;
        h_next       = h_reg;
        sq_next      = sq_reg;
        sv_next      = sv_reg;
        sum_next     = sum_reg;
        y_out_next   = y_out_reg;
        sat_out_next = sat_out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    u_next     = s_u_sample;
                    phase_next = PH_A;
                    state_next = ST_LOAD;
                    if (s_restart) begin
                        yc_next = y_init_reg;
                        ye_next = y_init_reg;
                        ue_next = '0;
                    end
                end
            end
            ST_LOAD: begin
                cnt_next   = '0;
                acc_next   = '0;
                rem_next   = '0;
                state_next = ST_MUL;
                case (phase_reg)
                    PH_A: begin
                        mcand_next = MCAND_W'(yc_reg);
                        lo_next    = MPLIER_W'(coef_a_reg);
                    end
                    PH_SQ: begin
                        mcand_next = MCAND_W'(ye_reg);
                        lo_next    = MPLIER_W'(ye_reg);
                    end
                    PH_B2: begin
                        mcand_next = sq_reg;
                        lo_next    = MPLIER_W'(coef_b_reg);
                    end
                    PH_C: begin
                        mcand_next = MCAND_W'(u_reg);
                        lo_next    = MPLIER_W'(coef_c_reg);
                    end
                    PH_BL: begin
                        mcand_next = MCAND_W'(u_reg);
                        lo_next    = MPLIER_W'(coef_b_reg);
                    end
                    PH_MOD: begin
                        sh_next    = {u_mag, 16'd0};
                        neg_next   = 1'b0;
                        state_next = ST_MOD;
                    end
                    PH_X2: begin
                        // The folded angle now sits in the remainder, still in unsigned Q4.32.
                        x_next     = rem_reg[33:2];
                        mcand_next = MCAND_W'(rem_reg[33:2]);
                        lo_next    = {1'b0, rem_reg[33:2]};
                    end
                    PH_D72: begin
                        sh_next    = {x2_reg, 15'd0};
                        state_next = ST_DIV;
                    end
                    PH_D42, PH_D20, PH_D6: begin
                        sh_next    = {t_reg, 15'd0};
                        state_next = ST_DIV;
                    end
                    PH_H42, PH_H20, PH_H6: begin
                        mcand_next = MCAND_W'(x2_reg);
                        lo_next    = h_reg;
                    end
                    PH_S: begin
                        mcand_next = MCAND_W'(x_reg);
                        lo_next    = h_reg;
                    end
                    PH_D: begin
                        mcand_next = MCAND_W'(sv_reg);
                        lo_next    = MPLIER_W'(coef_d_reg);
                    end
                    default: begin
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_MUL: begin
                acc_next = acc_sum[ACC_W:1];
                lo_next  = {acc_sum[0], lo_reg[MPLIER_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_POST;
                end
            end
            ST_DIV, ST_MOD: begin
                rem_next = trial_ge ? (trial - divisor) : trial;
                sh_next  = {sh_reg[SHIFT_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (state_reg == ST_DIV && cnt_reg == DIV_LAST) begin
                    state_next = ST_POST;
                end else if (state_reg == ST_MOD && cnt_reg == MOD_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                // Floor remainder, then fold into half a turn and a quarter turn.
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0) begin
                    if (ue_reg[DATA_W-1] && rem_reg != '0) begin
                        rem_next = PI2_Q32 - rem_reg;
                    end
                end else if (cnt_reg == FOLD_LAST) begin
                    if (rem_reg > PIH_Q32) begin
                        rem_next = PI_Q32 - rem_reg;
                    end
                    phase_next = PH_X2;
                    state_next = ST_LOAD;
                end else begin
                    if (rem_reg >= PI_Q32) begin
                        rem_next = rem_reg - PI_Q32;
                        neg_next = 1'b1;
                    end
                end
            end
            ST_POST: begin
                state_next = ST_LOAD;
                phase_next = phase_t'(phase_reg + 4'd1);
                case (phase_reg)
                    PH_A: begin
                        sum_next = $signed(p_hi + SUM_W'(p_rnd));
                        if (!mode_reg) begin
                            phase_next = PH_BL;
                        end
                    end
                    PH_SQ: begin
                        sq_next = p_hi[MCAND_W-1:0] + MCAND_W'(p_rnd);
                    end
                    PH_B2: begin
                        sum_next = $signed(sum_reg + $signed(~p_hi) + SUM_W'(!p_rnd));
                    end
                    PH_C: begin
                        sum_next = $signed(sum_reg + $signed(p_hi) + SUM_W'(p_rnd));
                    end
                    PH_X2: begin
                        x2_next = prod[62:30];
                    end
                    PH_H42, PH_H20, PH_H6: begin
                        t_next = prod[62:30];
                    end
                    PH_D72, PH_D42, PH_D20, PH_D6: begin
                        h_next = ONE_Q30 - sh_reg[MPLIER_W-1:0];
                    end
                    PH_S: begin
                        sv_next = neg_reg ? -$signed(v_mag) : $signed(v_mag);
                    end
                    PH_D, PH_BL: begin
                        sum_next   = $signed(sum_reg + $signed(p_hi) + SUM_W'(p_rnd));
                        state_next = ST_FIN;
                    end
                    default: begin
                        state_next = ST_LOAD;
                    end
                endcase
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    sat_out_next = sum_hi || sum_lo;
                    if (sum_hi) begin
                        y_out_next = {1'b0, {(DATA_W-1){1'b1}}};
                    end else if (sum_lo) begin
                        y_out_next = {1'b1, {(DATA_W-1){1'b0}}};
                    end else begin
                        y_out_next = sum_reg[DATA_W-1:0];
                    end
                    ye_next    = yc_reg;
                    yc_next    = y_out_next;
                    ue_next    = u_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_A;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            mode_reg    <= 1'b1;
            coef_a_reg  <= COEF_A_RESET;
            coef_b_reg  <= COEF_B_RESET;
            coef_c_reg  <= COEF_C_RESET;
            coef_d_reg  <= COEF_D_RESET;
            y_init_reg  <= Y_INIT_RESET;
            yc_reg      <= Y_INIT_RESET;
            ye_reg      <= Y_INIT_RESET;
            ue_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            yc_reg      <= yc_next;
            ye_reg      <= ye_next;
            ue_reg      <= ue_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_COEF_A: coef_a_reg <= cfg_data;
                    REG_COEF_B: coef_b_reg <= cfg_data;
                    REG_COEF_C: coef_c_reg <= cfg_data;
                    REG_COEF_D: coef_d_reg <= cfg_data;
                    REG_Y_INIT: y_init_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        u_reg       <= u_next;
        mcand_reg   <= mcand_next;
        acc_reg     <= acc_next;
        lo_reg      <= lo_next;
        rem_reg     <= rem_next;
        sh_reg      <= sh_next;
        neg_reg     <= neg_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        t_reg       <= t_next;
        h_reg       <= h_next;
        sq_reg      <= sq_next;
        sv_reg      <= sv_next;
        sum_reg     <= sum_next;
        y_out_reg   <= y_out_next;
        sat_out_reg <= sat_out_next;
    end

    // The core goes busy right after it takes a request.
    `ASSERT_NEXT(busy_after_request, s_valid && s_ready, !s_ready)
    // The multiplier never runs past the top bit of its operand.
    `ASSERT_IMPLIES(mul_count_bound, state_reg == ST_MUL, cnt_reg <= MUL_LAST)
    // A clipped result is always one of the two range limits.
    `ASSERT_IMPLIES(sat_at_limit, m_valid && m_saturated,
        m_y_next == {1'b0, {(DATA_W-1){1'b1}}} || m_y_next == {1'b1, {(DATA_W-1){1'b0}}})

endmodule
